// ===== rtl/core/bsdm_pkg.sv =====
// shared types, codes and constants of the block sparse times dense multiply core
package bsdm_pkg;

  localparam int MAX_ROWS_DEF        = 64;
  localparam int MAX_COLS_DEF        = 64;
  localparam int MAX_B_COLS_DEF      = 16;
  localparam int MAX_BLOCK_WIDTH_DEF = 16;

  // configuration register widths
  localparam int BCOLS_W = 5;
  localparam int BW_W    = 5;
  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 7;
  localparam int CFG_DW  = 7;

  // block_col * block_width + in_block_col
  localparam int KROW_W = 11;

  typedef enum logic [1:0] {
    REQ_WR_B = 2'd0,
    REQ_WR_C = 2'd1,
    REQ_ACC  = 2'd2,
    REQ_RD_C = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_B_COLS      = 2'd0,
    CFG_BLOCK_WIDTH = 2'd1,
    CFG_ROW_COUNT   = 2'd2,
    CFG_COL_COUNT   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [5:0]         row_index;
    logic [3:0]         col_index;
    logic [5:0]         block_col;
    logic [3:0]         in_block_col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic               status;
  } out_item_t;

  function automatic int addr_width(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== rtl/core/bsdm_ram.sv =====
// simple dual-port memory: one write port, one read port with registered data
module bsdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = bsdm_pkg::MAX_COLS_DEF * bsdm_pkg::MAX_B_COLS_DEF,
  localparam int AW = bsdm_pkg::addr_width(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bsdm_mac.sv =====
// shared multiply-accumulate unit: registered product, then add into the C entry
module bsdm_mac #(
  parameter int AW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [63:0]        c,
  input  logic [AW-1:0]      addr,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [63:0]        wr_data
);

  import bsdm_pkg::*;

  logic               valid_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;
  logic [63:0]        c_r;
  logic [AW-1:0]      addr_r;

  // 32x32 signed product, sign-extended operands
  assign prod_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      prod_r <= prod_nxt;
      c_r    <= c;
      addr_r <= addr;
    end
  end

  // wraps modulo 2^64
  assign wr_en   = valid_r;
  assign wr_addr = addr_r;
  assign wr_data = c_r + prod_r;

endmodule

// ===== rtl/core/block_sparse_dense_matmul_core.sv =====
// top level: request decode, column sequencer, B and C memories, result register
// sequence: a write or C read goes from the accept beat to S_RESP, then into the output register;
//   an accumulate runs S_ACC (one column per cycle through the shared mac), S_DRAIN, then S_RESP
// throughput: one item at a time, next beat taken once the result sits in the output register
// the column loop through the single multiply-accumulate unit sets the accumulate time
// reset: synchronous active-low rst_n clears control state and config registers;
//   B and C memories are not cleared and must be written by the host before use
module block_sparse_dense_matmul_core #(
  parameter int MAX_ROWS        = bsdm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS        = bsdm_pkg::MAX_COLS_DEF,
  parameter int MAX_B_COLS      = bsdm_pkg::MAX_B_COLS_DEF,
  parameter int MAX_BLOCK_WIDTH = bsdm_pkg::MAX_BLOCK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsdm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsdm_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  bsdm_pkg::cfg_index_t          cfg_index,
  input  logic [bsdm_pkg::CFG_DW-1:0]   cfg_wdata
);

  import bsdm_pkg::*;

  localparam int B_DEPTH = MAX_COLS * MAX_B_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_B_COLS;
  localparam int B_AW    = addr_width(B_DEPTH);
  localparam int C_AW    = addr_width(C_DEPTH);
  localparam int JW      = addr_width(MAX_B_COLS);
  localparam int CW      = (JW + 1 > BCOLS_W) ? JW + 1 : BCOLS_W;

  // configuration
  logic [BCOLS_W-1:0] b_cols_r;
  logic [BW_W-1:0]    block_width_r;
  logic [ROWS_W-1:0]  row_count_r;
  logic [COLS_W-1:0]  col_count_r;

  logic [BCOLS_W-1:0] nb;
  logic [BW_W-1:0]    bw;
  logic [ROWS_W-1:0]  nr;
  logic [COLS_W-1:0]  nc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cols_r      <= BCOLS_W'(1);
      block_width_r <= BW_W'(1);
      row_count_r   <= ROWS_W'(64);
      col_count_r   <= COLS_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_B_COLS:      b_cols_r      <= cfg_wdata[BCOLS_W-1:0];
        CFG_BLOCK_WIDTH: block_width_r <= cfg_wdata[BW_W-1:0];
        CFG_ROW_COUNT:   row_count_r   <= cfg_wdata[ROWS_W-1:0];
        CFG_COL_COUNT:   col_count_r   <= cfg_wdata[COLS_W-1:0];
      endcase
    end
  end

  // registers above their maximum act as saturated
  assign nb = (int'(b_cols_r) > MAX_B_COLS) ? BCOLS_W'(MAX_B_COLS) : b_cols_r;
  assign bw = (int'(block_width_r) > MAX_BLOCK_WIDTH) ? BW_W'(MAX_BLOCK_WIDTH) : block_width_r;
  assign nr = (int'(row_count_r) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : row_count_r;
  assign nc = (int'(col_count_r) > MAX_COLS) ? COLS_W'(MAX_COLS) : col_count_r;

  // request decode
  logic              accept;
  logic [KROW_W-1:0] krow_c;
  logic              row_c_ok;
  logic              row_b_ok;
  logic              col_ok;
  logic              acc_ok;
  logic              req_ok_c;

  assign accept   = in_valid && !in_stall;
  assign krow_c   = KROW_W'(in_data.block_col) * KROW_W'(bw) + KROW_W'(in_data.in_block_col);
  assign row_c_ok = ROWS_W'(in_data.row_index) < nr;
  assign row_b_ok = COLS_W'(in_data.row_index) < nc;
  assign col_ok   = BCOLS_W'(in_data.col_index) < nb;
  assign acc_ok   = row_c_ok && (BW_W'(in_data.in_block_col) < bw) && (krow_c < KROW_W'(nc));

  always_comb begin
    unique case (in_data.req_type)
      REQ_WR_B: req_ok_c = row_b_ok && col_ok;
      REQ_WR_C: req_ok_c = row_c_ok && col_ok;
      REQ_ACC:  req_ok_c = acc_ok;
      REQ_RD_C: req_ok_c = row_c_ok && col_ok;
    endcase
  end

  // held request
  state_t             state_r, state_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  req_type_t          req_r;
  logic               ok_r;
  logic [5:0]         row_r;
  logic [KROW_W-1:0]  krow_r;
  logic signed [31:0] val_r;
  logic               v1_r;
  logic [C_AW-1:0]    c_addr1_r;

  // memory and mac wiring
  logic              b_we;
  logic              b_re;
  logic [B_AW-1:0]   b_waddr;
  logic [B_AW-1:0]   b_raddr;
  logic [31:0]       b_rdata;
  logic              c_in_we;
  logic              c_we;
  logic              c_re;
  logic [C_AW-1:0]   c_in_addr;
  logic [C_AW-1:0]   c_acc_addr;
  logic [C_AW-1:0]   c_raddr;
  logic [C_AW-1:0]   c_waddr;
  logic [63:0]       c_wdata;
  logic [63:0]       c_rdata;
  logic              issue;
  logic              last_col;
  logic              mac_we;
  logic [C_AW-1:0]   mac_addr;
  logic [63:0]       mac_sum;

  // output register
  logic              out_load;
  logic              out_valid_r;
  out_item_t         out_data_r;

  assign b_waddr    = B_AW'(in_data.row_index) * B_AW'(MAX_B_COLS) + B_AW'(in_data.col_index);
  assign b_raddr    = B_AW'(krow_r) * B_AW'(MAX_B_COLS) + B_AW'(j_r);
  assign c_in_addr  = C_AW'(in_data.row_index) * C_AW'(MAX_B_COLS) + C_AW'(in_data.col_index);
  assign c_acc_addr = C_AW'(row_r) * C_AW'(MAX_B_COLS) + C_AW'(j_r);
  assign c_raddr    = (state_r == S_ACC) ? c_acc_addr : c_in_addr;
  assign last_col   = (CW'(j_r) + CW'(1)) == CW'(nb);

  // the mac only writes during accumulate, host writes only on the accept beat
  assign c_we    = mac_we || c_in_we;
  assign c_waddr = mac_we ? mac_addr : c_in_addr;
  assign c_wdata = mac_we ? mac_sum : 64'(in_data.value);

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    b_we      = 1'b0;
    b_re      = 1'b0;
    c_in_we   = 1'b0;
    c_re      = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_ok_c) begin
            unique case (in_data.req_type)
              REQ_WR_B: b_we    = 1'b1;
              REQ_WR_C: c_in_we = 1'b1;
              REQ_RD_C: c_re    = 1'b1;
              REQ_ACC: begin
              end
            endcase
          end
          j_nxt = '0;
          if (in_data.req_type == REQ_ACC && req_ok_c && nb != '0) begin
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_ACC: begin
        issue = 1'b1;
        b_re  = 1'b1;
        c_re  = 1'b1;
        j_nxt = j_r + JW'(1);
        if (last_col) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !mac_we) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    if (issue) begin
      c_addr1_r <= c_acc_addr;
    end
    if (accept) begin
      req_r  <= in_data.req_type;
      ok_r   <= req_ok_c;
      row_r  <= in_data.row_index;
      krow_r <= krow_c;
      val_r  <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.read_value <= (req_r == REQ_RD_C && ok_r) ? c_rdata : '0;
      out_data_r.status     <= !ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bsdm_ram #(
    .WIDTH(32),
    .DEPTH(B_DEPTH)
  ) u_b_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(in_data.value),
    .re   (b_re),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  bsdm_ram #(
    .WIDTH(64),
    .DEPTH(C_DEPTH)
  ) u_c_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(c_wdata),
    .re   (c_re),
    .raddr(c_raddr),
    .rdata(c_rdata)
  );

  bsdm_mac #(
    .AW(C_AW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_valid(v1_r),
    .a       (val_r),
    .b       (b_rdata),
    .c       (c_rdata),
    .addr    (c_addr1_r),
    .wr_en   (mac_we),
    .wr_addr (mac_addr),
    .wr_data (mac_sum)
  );

  // the mac never writes while a host write could use the C port
  a_mac_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mac_we)
    else $error("mac write outside accumulate");

  // column counter stays below b_cols while issuing
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (CW'(j_r) < CW'(nb)))
    else $error("column counter past b_cols");

  // result is only formed once the mac pipeline has emptied
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> (!v1_r && !mac_we))
    else $error("result before accumulate drained");

  // an ignored request never returns data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |-> (out_data_r.read_value == '0))
    else $error("error status with nonzero read data");

  // accumulate enters the column loop only for an in-range request
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_ACC) |=> (ok_r && req_r == REQ_ACC))
    else $error("column loop started for a rejected request");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the block sparse times dense multiply core
module tb;
  import bsdm_pkg::*;

  localparam int NROWS = MAX_ROWS_DEF;
  localparam int NCOLS = MAX_COLS_DEF;
  localparam int NBC   = MAX_B_COLS_DEF;
  localparam int NBW   = MAX_BLOCK_WIDTH_DEF;
  // room for a few thousand requests plus the hold-off
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 24;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  cfg_index_t        cfg_index = CFG_B_COLS;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  block_sparse_dense_matmul_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // effective (saturated) register values
  int eff_bcols = 1;
  int eff_bw    = 1;
  int eff_rows  = NROWS;
  int eff_cols  = NCOLS;

  logic signed [31:0] b_mem [NCOLS][NBC];
  logic signed [63:0] c_mem [NROWS][NBC];
  bit                 b_written [NCOLS][NBC];
  bit                 c_written [NROWS][NBC];

  in_item_t  requests_pending [$];
  out_item_t responses_due [$];
  out_item_t due_resp;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_rejected = 0;
  int n_errors   = 0;
  int n_settings = 0;
  int send_gap   = 0;
  int stall_left = 0;
  int cycles     = 0;
  bit calm       = 1'b0;
  bit hold_off   = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int sat(int x, int lim);
    return (x > lim) ? lim : x;
  endfunction

  function automatic bit req_ok(in_item_t it);
    int krow;
    krow = int'(it.block_col) * eff_bw + int'(it.in_block_col);
    case (it.req_type)
      REQ_WR_B: return it.row_index < eff_cols && it.col_index < eff_bcols;
      REQ_ACC:  return it.row_index < eff_rows && it.in_block_col < eff_bw && krow < eff_cols;
      default:  return it.row_index < eff_rows && it.col_index < eff_bcols;
    endcase
  endfunction

  // updates the B and C copies and returns the response the core owes
  function automatic out_item_t mac_response(in_item_t it);
    out_item_t resp;
    int krow;
    int j;
    resp = '0;
    resp.status = 1'b1;
    krow = int'(it.block_col) * eff_bw + int'(it.in_block_col);
    if (req_ok(it)) begin
      resp.status = 1'b0;
      case (it.req_type)
        REQ_WR_B: b_mem[it.row_index][it.col_index] = it.value;
        REQ_WR_C: c_mem[it.row_index][it.col_index] = longint'(it.value);
        REQ_ACC: begin
          for (j = 0; j < eff_bcols; j++)
            c_mem[it.row_index][j] = c_mem[it.row_index][j] +
                                     longint'(it.value) * longint'(b_mem[krow][j]);
        end
        default: resp.read_value = c_mem[it.row_index][it.col_index];
      endcase
    end
    return resp;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // in range most of the time, anywhere in the field otherwise
  function automatic int pick(int hi, int full);
    if (hi > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, hi - 1);
    return $urandom_range(0, full);
  endfunction

  function automatic in_item_t make_req(req_type_t rt, int row, int col, int bc, int ibc,
                                        logic signed [31:0] v);
    in_item_t it;
    it.req_type     = rt;
    it.row_index    = 6'(row);
    it.col_index    = 4'(col);
    it.block_col    = 6'(bc);
    it.in_block_col = 4'(ibc);
    it.value        = v;
    return it;
  endfunction

  task automatic push_req(in_item_t it);
    if (req_ok(it)) begin
      if (it.req_type == REQ_WR_B) b_written[it.row_index][it.col_index] = 1'b1;
      if (it.req_type == REQ_WR_C) c_written[it.row_index][it.col_index] = 1'b1;
    end
    requests_pending = {requests_pending, it};
    n_queued++;
  endtask

  // fill any B or C entry the request would touch before it goes out
  task automatic send_safe(in_item_t it);
    int krow;
    int j;
    krow = int'(it.block_col) * eff_bw + int'(it.in_block_col);
    if (req_ok(it)) begin
      if (it.req_type == REQ_ACC) begin
        for (j = 0; j < eff_bcols; j++) begin
          if (!b_written[krow][j])
            push_req(make_req(REQ_WR_B, krow, j, $urandom_range(0, 63),
                              $urandom_range(0, 15), rand_value()));
          if (!c_written[it.row_index][j])
            push_req(make_req(REQ_WR_C, it.row_index, j, $urandom_range(0, 63),
                              $urandom_range(0, 15), rand_value()));
        end
      end else if (it.req_type == REQ_RD_C && !c_written[it.row_index][it.col_index]) begin
        push_req(make_req(REQ_WR_C, it.row_index, it.col_index, $urandom_range(0, 63),
                          $urandom_range(0, 15), rand_value()));
      end
    end
    push_req(it);
  endtask

  task automatic rand_request();
    int kind;
    int krow;
    in_item_t it;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      it = make_req(REQ_WR_B, pick(eff_cols, 63), pick(eff_bcols, 15),
                    $urandom_range(0, 63), $urandom_range(0, 15), rand_value());
    end else if (kind < 30) begin
      it = make_req(REQ_WR_C, pick(eff_rows, 63), pick(eff_bcols, 15),
                    $urandom_range(0, 63), $urandom_range(0, 15), rand_value());
    end else if (kind < 75) begin
      if (eff_rows > 0 && eff_bw > 0 && eff_cols > 0 && $urandom_range(0, 9) < 9) begin
        krow = $urandom_range(0, eff_cols - 1);
        it = make_req(REQ_ACC, $urandom_range(0, eff_rows - 1), $urandom_range(0, 15),
                      krow / eff_bw, krow % eff_bw, rand_value());
      end else begin
        it = make_req(REQ_ACC, $urandom_range(0, 63), $urandom_range(0, 15),
                      $urandom_range(0, 63), $urandom_range(0, 15), rand_value());
      end
    end else begin
      it = make_req(REQ_RD_C, pick(eff_rows, 63), pick(eff_bcols, 15),
                    $urandom_range(0, 63), $urandom_range(0, 15), rand_value());
    end
    send_safe(it);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || responses_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DW-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_B_COLS:      eff_bcols = sat(v[BCOLS_W-1:0], NBC);
      CFG_BLOCK_WIDTH: eff_bw    = sat(v[BW_W-1:0], NBW);
      CFG_ROW_COUNT:   eff_rows  = sat(v[ROWS_W-1:0], NROWS);
      default:         eff_cols  = sat(v[COLS_W-1:0], NCOLS);
    endcase
  endtask

  task automatic apply_setting(int bc, int bw, int rows, int cols);
    write_reg(CFG_B_COLS, CFG_DW'(bc));
    write_reg(CFG_BLOCK_WIDTH, CFG_DW'(bw));
    write_reg(CFG_ROW_COUNT, CFG_DW'(rows));
    write_reg(CFG_COL_COUNT, CFG_DW'(cols));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // driver: one beat per handshake, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        responses_due = {responses_due, mac_response(in_data)};
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          in_data  <= requests_pending.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest response due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (responses_due.size() == 0) begin
        $display("%0t: result beat with nothing due, read_value=%0d status=%0b",
                 $time, out_data.read_value, out_data.status);
        n_errors++;
      end else begin
        due_resp = responses_due.pop_front();
        if (out_data.read_value !== due_resp.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, due_resp.read_value, out_data.read_value);
          n_errors++;
        end
        if (out_data.status !== due_resp.status) begin
          $display("%0t: status expected %0b actual %0b",
                   $time, due_resp.status, out_data.status);
          n_errors++;
        end
        n_checked++;
        if (due_resp.status) n_rejected++;
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall  <= hold_off;
    end
  end

  // long receiver hold-off so the core backs up into its input
  initial begin
    while (n_accepted < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still due", cycles,
               responses_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : main_seq
    int phase;
    int quota;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset setting: b_cols 1, block_width 1, 64 rows, 64 columns
    send_safe(make_req(REQ_WR_B, 63, 0, 0, 0, VAL_MIN));
    send_safe(make_req(REQ_WR_B, 0, 0, 63, 15, VAL_MAX));
    send_safe(make_req(REQ_WR_C, 63, 0, 0, 0, VAL_MAX));
    send_safe(make_req(REQ_WR_C, 0, 0, 0, 0, VAL_MIN));
    // min times min three times, the sum wraps past the largest signed 64-bit value
    repeat (3) send_safe(make_req(REQ_ACC, 63, 0, 63, 0, VAL_MIN));
    send_safe(make_req(REQ_RD_C, 63, 0, 0, 0, 0));
    send_safe(make_req(REQ_ACC, 0, 15, 0, 0, VAL_MAX));
    send_safe(make_req(REQ_RD_C, 0, 0, 0, 0, 0));
    // out of range: column past b_cols, offset past block_width
    send_safe(make_req(REQ_WR_B, 5, 15, 0, 0, -1));
    send_safe(make_req(REQ_WR_C, 5, 1, 0, 0, -1));
    send_safe(make_req(REQ_RD_C, 63, 15, 0, 0, 0));
    send_safe(make_req(REQ_ACC, 0, 0, 0, 15, VAL_MAX));
    send_safe(make_req(REQ_ACC, 63, 0, 63, 1, VAL_MIN));
    // zero B entry leaves C alone
    send_safe(make_req(REQ_WR_B, 63, 0, 0, 0, 0));
    send_safe(make_req(REQ_ACC, 63, 0, 63, 0, -1));
    send_safe(make_req(REQ_RD_C, 63, 0, 0, 0, 0));
    send_safe(make_req(REQ_WR_C, 0, 0, 0, 0, 0));
    send_safe(make_req(REQ_RD_C, 0, 0, 0, 0, 0));
    wait_idle();

    for (phase = 0; phase < 14; phase++) begin
      case (phase)
        0: apply_setting(16, 16, 64, 64);
        1: apply_setting(1, 16, 1, 16);
        2: apply_setting(7'h7F, 7'h7F, 7'h7F, 7'h7F);
        3: apply_setting(0, 0, 0, 0);
        4: apply_setting(0, 4, 8, 64);
        5: apply_setting(4, 0, 8, 64);
        6: apply_setting(4, 4, 64, 0);
        7: apply_setting(1, 1, 64, 64);
        default: apply_setting($urandom_range(1, $urandom_range(0, 1) ? 4 : 16),
                               $urandom_range(1, 16), $urandom_range(1, 64),
                               $urandom_range(1, 64));
      endcase
      calm  = ($urandom_range(0, 3) == 0);
      quota = n_queued + ((phase == 3) ? 40 : 100);
      while (n_queued < quota) rand_request();
      wait_idle();
    end

    $display("checked %0d responses under %0d register settings, %0d were rejections",
             n_checked, n_settings, n_rejected);
    $display("mix of B and C writes, block accumulates and C reads incl. zero and saturated sizes");
    if (n_errors == 0 && responses_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
